// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants for the stable priority queue
// Queue depth, field widths, operation and status codes, cell structs.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PRIO_W      = 8;
    localparam int HANDLE_W    = 16;
    localparam int STATUS_W    = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // command broadcast to every cell in the same cycle
    typedef struct packed {
        logic                ins;
        logic                pop;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

    // contents of one cell as seen by its neighbours
    typedef struct packed {
        logic                valid;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

endpackage

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted shift chain
// Keeps its entry, takes the new entry, takes its upper neighbour's entry
// (insert shifts down) or its lower neighbour's entry (pop shifts up).
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spq_pkg::t_cmd   i_cmd,
    input  spq_pkg::t_entry i_prev,
    input  logic            i_prev_keep,
    input  spq_pkg::t_entry i_next,
    output spq_pkg::t_entry o_entry,
    output logic            o_keep
);
    import spq_pkg::*;

    logic                r_valid;
    logic [PRIO_W-1:0]   r_prio;
    logic [HANDLE_W-1:0] r_handle;
    t_entry              n_entry;
    logic                w_keep;

    // equal priority stays ahead of the newcomer, giving arrival order on ties
    assign w_keep = r_valid && (r_prio >= i_cmd.prio);

    always_comb begin
        n_entry = '{valid: r_valid, prio: r_prio, handle: r_handle};
        if (i_cmd.ins) begin
            if (!w_keep) begin
                if (i_prev_keep) begin
                    n_entry = '{valid: 1'b1, prio: i_cmd.prio, handle: i_cmd.handle};
                end else begin
                    n_entry = i_prev;
                end
            end
        end else if (i_cmd.pop) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio   <= n_entry.prio;
        r_handle <= n_entry.handle;
    end

    assign o_entry = '{valid: r_valid, prio: r_prio, handle: r_handle};
    assign o_keep  = w_keep;

endmodule

// ----- rtl/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue - bounded priority queue, ties leave in arrival order
//
// Input channel (i_in_valid / o_in_ready) carries one operation per
// transaction: insert of a handle with its priority, or pop of the head entry.
// Output channel (o_out_valid / i_out_ready) returns exactly one result per
// input transaction: inserted, popped (with handle and priority), empty, or
// full (insert rejected). Non-pop results carry zero handle and priority.
// Storage is a chain of QUEUE_DEPTH cells kept sorted by descending priority;
// every cell decides its next contents from its neighbours.
// The result is registered and appears in the cycle after the input transaction.
// One transaction is accepted per cycle while the input is not stalled.
// The output register is refilled in the same cycle it is drained, so the
// input only stalls while a result is held and the receiver is not ready.
// Reset empties the queue and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
module stable_priority_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic [spq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [spq_pkg::HANDLE_W-1:0] i_message_handle,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [spq_pkg::STATUS_W-1:0] o_status,
    output logic [spq_pkg::HANDLE_W-1:0] o_out_handle,
    output logic [spq_pkg::PRIO_W-1:0]   o_out_priority
);
    import spq_pkg::*;

    t_entry                w_entry     [QUEUE_DEPTH];
    logic                  w_keep      [QUEUE_DEPTH];
    t_entry                w_prev      [QUEUE_DEPTH];
    logic                  w_prev_keep [QUEUE_DEPTH];
    t_entry                w_next      [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid_vec;

    logic    w_accept;
    logic    w_is_pop;
    logic    w_full;
    logic    w_empty;
    t_cmd    w_cmd;

    logic                r_out_valid;
    t_status             r_status;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [PRIO_W-1:0]   r_out_priority;
    t_status             n_status;
    logic [HANDLE_W-1:0] n_out_handle;
    logic [PRIO_W-1:0]   n_out_priority;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_pop   = (t_op'(i_operation) == OP_POP);

    // occupancy is a thermometer from cell 0 upward
    assign w_full  = w_entry[QUEUE_DEPTH-1].valid;
    assign w_empty = !w_entry[0].valid;

    assign w_cmd.ins    = w_accept && !w_is_pop && !w_full;
    assign w_cmd.pop    = w_accept && w_is_pop && !w_empty;
    assign w_cmd.prio   = i_priority_req;
    assign w_cmd.handle = i_message_handle;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_prev[g]      = '0;
                assign w_prev_keep[g] = 1'b1;
            end else begin : g_body
                assign w_prev[g]      = w_entry[g-1];
                assign w_prev_keep[g] = w_keep[g-1];
            end
            if (g == QUEUE_DEPTH-1) begin : g_tail
                assign w_next[g] = '0;
            end else begin : g_inner
                assign w_next[g] = w_entry[g+1];
            end
            assign w_valid_vec[g] = w_entry[g].valid;

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_prev      (w_prev[g]),
                .i_prev_keep (w_prev_keep[g]),
                .i_next      (w_next[g]),
                .o_entry     (w_entry[g]),
                .o_keep      (w_keep[g])
            );
        end
    endgenerate

    always_comb begin
        n_out_handle   = '0;
        n_out_priority = '0;
        if (w_is_pop) begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status       = ST_POPPED;
                n_out_handle   = w_entry[0].handle;
                n_out_priority = w_entry[0].prio;
            end
        end else begin
            n_status = w_full ? ST_FULL : ST_INSERTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status       <= n_status;
            r_out_handle   <= n_out_handle;
            r_out_priority <= n_out_priority;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_handle   = r_out_handle;
    assign o_out_priority = r_out_priority;

    // occupied cells always form a contiguous run from the head
    a_thermometer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec & (w_valid_vec + 1'b1)) == '0)
        else $error("occupied cells not contiguous");

    // an accepted insert into a non-full queue adds exactly one entry
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> ($countones(w_valid_vec) == $past($countones(w_valid_vec)) + 1))
        else $error("insert did not add one entry");

    // a pop of a non-empty queue returns a popped result next cycle
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |=> (r_out_valid && r_status == ST_POPPED))
        else $error("pop result missing");

    // chain stays sorted by descending priority
    generate
        for (g = 1; g < QUEUE_DEPTH; g++) begin : g_sorted
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_entry[g].valid |-> (w_entry[g-1].prio >= w_entry[g].prio))
                else $error("queue order broken");
        end
    endgenerate

endmodule

// ----- dv/stable_priority_queue_tb.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue_tb - self-checking bench for the stable priority queue
// A directed table covers empty pop, extreme fields, equal-priority ordering,
// full rejection and ignored pop fields. Random phases of insert-heavy,
// pop-heavy and mixed traffic follow. Each result is checked against a
// behavioural model or fixed table result, with random idling on both channels.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int QUIET_FROM   = 730;   // no idling from this item onwards
    localparam int WATCHDOG_MAX = 500;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
    } t_result;

    typedef struct {
        t_op                 op;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
        bit                  fixed;     // expected result typed into the table
        t_result             want;
    } t_queue_cmd;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_operation;
    logic [PRIO_W-1:0]   i_priority_req;
    logic [HANDLE_W-1:0] i_message_handle;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [PRIO_W-1:0]   o_out_priority;

    // transaction currently on the input channel, seen by the monitor
    bit                  cur_fixed;
    t_result             cur_want;

    // behavioural copy of the queue
    logic [PRIO_W-1:0]   pq_prio   [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] pq_handle [QUEUE_DEPTH];
    int                  pq_fill;

    t_result             pending_results[$];
    t_queue_cmd          directed_cmds[$];
    int                  error_count = 0;
    int                  idle_cycles = 0;
    bit                  idle_on = 1'b0;

    stable_priority_queue uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_priority_req   (i_priority_req),
        .i_message_handle (i_message_handle),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_out_handle     (o_out_handle),
        .o_out_priority   (o_out_priority)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result queue_step(t_op op, logic [PRIO_W-1:0] prio,
                                           logic [HANDLE_W-1:0] handle);
        t_result r;
        int      pos;
        r.status = ST_INSERTED;
        r.handle = '0;
        r.prio   = '0;
        if (op == OP_INSERT) begin
            if (pq_fill >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // new entry goes behind all entries of equal or higher priority
                pos = 0;
                while (pos < pq_fill && pq_prio[pos] >= prio) pos++;
                for (int i = pq_fill; i > pos; i--) begin
                    pq_prio[i]   = pq_prio[i-1];
                    pq_handle[i] = pq_handle[i-1];
                end
                pq_prio[pos]   = prio;
                pq_handle[pos] = handle;
                pq_fill++;
            end
        end else begin
            if (pq_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status = ST_POPPED;
                r.handle = pq_handle[0];
                r.prio   = pq_prio[0];
                for (int i = 1; i < pq_fill; i++) begin
                    pq_prio[i-1]   = pq_prio[i];
                    pq_handle[i-1] = pq_handle[i];
                end
                pq_fill--;
            end
        end
        return r;
    endfunction

    function automatic t_queue_cmd mk_row(t_op op, int prio, int handle, bit fixed,
                                          t_status st, int want_h, int want_p);
        t_queue_cmd c;
        c.op          = op;
        c.prio        = prio[PRIO_W-1:0];
        c.handle      = handle[HANDLE_W-1:0];
        c.fixed       = fixed;
        c.want.status = st;
        c.want.handle = want_h[HANDLE_W-1:0];
        c.want.prio   = want_p[PRIO_W-1:0];
        return c;
    endfunction

    // monitor: predict on input transactions, check on output transactions
    always @(posedge i_clk) begin
        t_result pred;
        t_result want;
        bit      moved;
        if (!i_rst_n) begin
            pq_fill     = 0;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                pred  = queue_step(t_op'(i_operation), i_priority_req, i_message_handle);
                pending_results.push_back(cur_fixed ? cur_want : pred);
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result status=%0d handle=%h prio=%0d",
                             $time, o_status, o_out_handle, o_out_priority);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                    end
                    if (o_out_handle !== want.handle) begin
                        error_count++;
                        $display("%0t: handle expected %h actual %h",
                                 $time, want.handle, o_out_handle);
                    end
                    if (o_out_priority !== want.prio) begin
                        error_count++;
                        $display("%0t: priority expected %0d actual %0d",
                                 $time, want.prio, o_out_priority);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // receiver: random stall bursts while idling is enabled
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left  = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_MAX) @(posedge i_clk);
        $display("stable_priority_queue_tb: FAIL");
        $finish;
    end

    task automatic send_cmd(input t_queue_cmd c);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= c.op;
        i_priority_req   <= c.prio;
        i_message_handle <= c.handle;
        cur_fixed        <= c.fixed;
        cur_want         <= c.want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        while (pending_results.size() != 0 || o_out_valid) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        t_queue_cmd c;
        int         sent;
        int         mode;
        int         prio_mode;
        int         len;
        bit         phase_idle;
        bit         paused;
        int         tie_a;
        int         tie_b;

        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_operation      <= OP_INSERT;
        i_priority_req   <= '0;
        i_message_handle <= '0;
        cur_fixed        <= 1'b0;
        cur_want         <= '{ST_INSERTED, '0, '0};

        directed_cmds.push_back(mk_row(OP_POP,    0, 0,       1, ST_EMPTY,    0,       0));
        directed_cmds.push_back(mk_row(OP_INSERT, 0, 0,       1, ST_INSERTED, 0,       0));
        directed_cmds.push_back(mk_row(OP_INSERT, 255, 'hFFFF, 1, ST_INSERTED, 0,       0));
        directed_cmds.push_back(mk_row(OP_POP,    0, 0,       1, ST_POPPED,   'hFFFF, 255));
        // equal priorities must leave in arrival order
        directed_cmds.push_back(mk_row(OP_INSERT, 7, 'h1111,  0, ST_INSERTED, 0,       0));
        directed_cmds.push_back(mk_row(OP_INSERT, 7, 'h2222,  0, ST_INSERTED, 0,       0));
        directed_cmds.push_back(mk_row(OP_POP,    0, 0,       0, ST_INSERTED, 0,       0));
        // two entries left; fill the rest
        for (int i = 0; i < QUEUE_DEPTH - 2; i++)
            directed_cmds.push_back(mk_row(OP_INSERT, (i % 3 == 0) ? 7 : i * 37,
                                           'h1000 + i * 'h0111, 0, ST_INSERTED, 0, 0));
        directed_cmds.push_back(mk_row(OP_INSERT, 200, 'hABCD, 1, ST_FULL,    0,       0));
        // fields of a pop are ignored
        directed_cmds.push_back(mk_row(OP_POP,    255, 'hFFFF, 0, ST_INSERTED, 0,       0));
        directed_cmds.push_back(mk_row(OP_INSERT, 255, 'h5A5A, 0, ST_INSERTED, 0,       0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            mode       = $urandom_range(0, 3);
            prio_mode  = $urandom_range(0, 3);
            len        = $urandom_range(20, 70);
            phase_idle = ($urandom_range(0, 4) != 0);
            tie_a      = $urandom_range(0, 255);
            tie_b      = $urandom_range(0, 255);
            for (int j = 0; j < len && sent < RANDOM_ITEMS; j++) begin
                idle_on = phase_idle && (sent < QUIET_FROM);
                case (mode)
                    0: c.op = ($urandom_range(0, 99) < 85) ? OP_INSERT : OP_POP;
                    1: c.op = ($urandom_range(0, 99) < 85) ? OP_POP : OP_INSERT;
                    2: c.op = $urandom_range(0, 1) ? OP_POP : OP_INSERT;
                    default: c.op = ($urandom_range(0, 99) < 60) ? OP_INSERT : OP_POP;
                endcase
                case (prio_mode)
                    0: c.prio = PRIO_W'($urandom_range(0, 3) * 85);     // many ties
                    1: c.prio = PRIO_W'($urandom_range(0, 1) ? tie_a : tie_b);
                    2: c.prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    default: c.prio = PRIO_W'($urandom_range(0, 255));
                endcase
                c.handle = HANDLE_W'($urandom_range(0, 65535));
                c.fixed  = 1'b0;
                c.want   = '{ST_INSERTED, '0, '0};
                send_cmd(c);
                sent++;
            end
            if (!paused && sent > 300) begin
                paused = 1'b1;
                i_in_valid <= 1'b0;
                wait_all_results();
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        idle_on = 1'b0;

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("stable_priority_queue_tb: PASS");
        end else begin
            $display("stable_priority_queue_tb: FAIL");
        end
        $finish;
    end

endmodule
